@@ design/iir_tdf2_pkg.sv @@
// ----------------------------------------------------------------------------
// IIR transposed direct form II filter package
// Shared types, register indexes and constants for the filter block.
// ----------------------------------------------------------------------------
`default_nettype none

package iir_tdf2_pkg;

  localparam int FILTER_ORDER_DEF = 3;
  localparam int ORDER_MAX        = 3;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 18;
  localparam int STATE_W  = 40;
  localparam int PROD_W   = COEF_W + SAMPLE_W;
  localparam int ACC_W    = STATE_W + 2;
  localparam int FRAC_W   = 14;

  localparam int CFG_IDX_W  = 3;
  localparam logic signed [COEF_W-1:0] COEF_B0_RESET = 18'sd16384;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_B0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_B1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_B2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_B3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_A1 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_A2 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_A3 = 3'd6;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       restart;
  } iir_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] filtered;
    logic                       clipped;
  } iir_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_UPDATE,
    ST_PUBLISH
  } iir_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // capture the item and form b0*x
    logic round;    // form y from b0*x + s0
    logic mul;      // form b[k+1]*x and a[k+1]*y
    logic acc;      // write the next delay state
    logic publish;  // load the output register
  } iir_cmd_t;

endpackage

`default_nettype wire

@@ design/iir_tdf2_ctrl.sv @@
// ----------------------------------------------------------------------------
// IIR filter controller
// Sequences one item through round, state update and output publish steps.
// ----------------------------------------------------------------------------
`default_nettype none

module iir_tdf2_ctrl #(
  parameter int ORDER  = iir_tdf2_pkg::FILTER_ORDER_DEF,
  parameter int STEP_W = $clog2(ORDER + 1)
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_stall,
  output logic                    out_valid,
  input  wire                     out_stall,
  output iir_tdf2_pkg::iir_cmd_t  cmd,
  output logic [STEP_W-1:0]       step_idx
);
  import iir_tdf2_pkg::*;

  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(ORDER);

  iir_state_t        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign step_idx  = step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        state_nxt = ST_UPDATE;
        step_nxt  = '0;
      end
      ST_UPDATE: begin
        if (step_r == STEP_LAST) begin
          state_nxt = ST_PUBLISH;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_PUBLISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_IDLE:    cmd.load    = in_valid;
      ST_ROUND:   cmd.round   = 1'b1;
      ST_UPDATE: begin
        cmd.mul = (step_r != STEP_LAST);
        cmd.acc = (step_r != '0);
      end
      ST_PUBLISH: cmd.publish = out_free;
      default:    cmd = '0;
    endcase
    if (cmd.publish) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  a_accept_starts_round: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r == ST_ROUND)
    else $error("accepted item did not start the round step");

  a_publish_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |-> !out_valid_r || !out_stall)
    else $error("publish would overwrite a waiting result");

  a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_UPDATE |-> step_r <= STEP_LAST)
    else $error("update step counter out of range");

  a_last_step_publishes: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_UPDATE && step_r == STEP_LAST |=> state_r == ST_PUBLISH)
    else $error("last update step did not lead to publish");

endmodule

`default_nettype wire

@@ design/iir_tdf2_dp.sv @@
// ----------------------------------------------------------------------------
// IIR filter datapath
// Coefficient registers, shared multipliers, delay state line and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module iir_tdf2_dp #(
  parameter int ORDER  = iir_tdf2_pkg::FILTER_ORDER_DEF,
  parameter int STEP_W = $clog2(ORDER + 1)
) (
  input  wire                                      clk,
  input  wire                                      rst_n,
  input  iir_tdf2_pkg::iir_in_t                    in_data,
  output iir_tdf2_pkg::iir_out_t                   out_data,
  input  wire                                      cfg_valid,
  input  wire [iir_tdf2_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire [iir_tdf2_pkg::COEF_W-1:0]           cfg_data,
  input  iir_tdf2_pkg::iir_cmd_t                   cmd,
  input  wire [STEP_W-1:0]                         step_idx
);
  import iir_tdf2_pkg::*;

  localparam logic signed [ACC_W-1:0] STATE_MAX = ACC_W'({1'b0, {(STATE_W-1){1'b1}}});
  localparam logic signed [ACC_W-1:0] STATE_MIN = ~STATE_MAX;
  localparam logic signed [ACC_W-1:0] Y_MAX     = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] Y_MIN     = -ACC_W'(32768);
  localparam logic signed [ACC_W-1:0] RND_HALF  = ACC_W'(1 << (FRAC_W - 1));

  logic signed [COEF_W-1:0]   coef_b_r [0:3];
  logic signed [COEF_W-1:0]   coef_a_r [1:3];
  logic signed [SAMPLE_W-1:0] x_r;
  logic signed [SAMPLE_W-1:0] y_r;
  logic                       clip_r;
  logic signed [PROD_W-1:0]   prod_bx_r;
  logic signed [PROD_W-1:0]   prod_ay_r;
  logic signed [STATE_W-1:0]  state_r [0:ORDER-1];
  iir_out_t                   out_data_r;

  logic signed [COEF_W-1:0]   sel_b, sel_a, mul_coef;
  logic signed [SAMPLE_W-1:0] mul_x;
  logic signed [PROD_W-1:0]   prod_bx, prod_ay;
  logic signed [ACC_W-1:0]    acc_y, y_full;
  logic signed [SAMPLE_W-1:0] y_sat;
  logic                       y_clip;
  logic signed [ACC_W-1:0]    acc_s;
  logic signed [STATE_W-1:0]  s_sat;

  // Coefficient registers; an index past the last register is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_b_r[0] <= COEF_B0_RESET;
      coef_b_r[1] <= '0;
      coef_b_r[2] <= '0;
      coef_b_r[3] <= '0;
      coef_a_r[1] <= '0;
      coef_a_r[2] <= '0;
      coef_a_r[3] <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_COEF_B0: coef_b_r[0] <= cfg_data;
        CFG_COEF_B1: coef_b_r[1] <= cfg_data;
        CFG_COEF_B2: coef_b_r[2] <= cfg_data;
        CFG_COEF_B3: coef_b_r[3] <= cfg_data;
        CFG_COEF_A1: coef_a_r[1] <= cfg_data;
        CFG_COEF_A2: coef_a_r[2] <= cfg_data;
        CFG_COEF_A3: coef_a_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    sel_b = coef_b_r[3];
    sel_a = coef_a_r[3];
    if (step_idx == STEP_W'(0)) begin
      sel_b = coef_b_r[1];
      sel_a = coef_a_r[1];
    end else if (step_idx == STEP_W'(1)) begin
      sel_b = coef_b_r[2];
      sel_a = coef_a_r[2];
    end
    mul_coef = cmd.load ? coef_b_r[0] : sel_b;
    mul_x    = cmd.load ? in_data.sample : x_r;
  end

  assign prod_bx = mul_coef * mul_x;
  assign prod_ay = sel_a * y_r;

  // Output: round half up at the Q.14 point, then saturate to 16 bits.
  always_comb begin
    acc_y  = ACC_W'(prod_bx_r) + ACC_W'(state_r[0]) + RND_HALF;
    y_full = acc_y >>> FRAC_W;
    y_clip = 1'b1;
    if (y_full > Y_MAX) begin
      y_sat = Y_MAX[SAMPLE_W-1:0];
    end else if (y_full < Y_MIN) begin
      y_sat = Y_MIN[SAMPLE_W-1:0];
    end else begin
      y_sat  = y_full[SAMPLE_W-1:0];
      y_clip = 1'b0;
    end
  end

  // Next delay state. The line has shifted so that the old s[k+1] sits at the
  // bottom tap; above the filter order a zero has been shifted in.
  always_comb begin
    acc_s = ACC_W'(prod_bx_r) - ACC_W'(prod_ay_r) + ACC_W'(state_r[0]);
    if (acc_s > STATE_MAX) begin
      s_sat = STATE_MAX[STATE_W-1:0];
    end else if (acc_s < STATE_MIN) begin
      s_sat = STATE_MIN[STATE_W-1:0];
    end else begin
      s_sat = acc_s[STATE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r <= in_data.sample;
    end
    if (cmd.load || cmd.mul) begin
      prod_bx_r <= prod_bx;
    end
    if (cmd.mul) begin
      prod_ay_r <= prod_ay;
    end
    if (cmd.round) begin
      y_r    <= y_sat;
      clip_r <= y_clip;
    end
    if (cmd.publish) begin
      out_data_r.filtered <= y_r;
      out_data_r.clipped  <= clip_r;
    end
  end

  // Delay state line: the round step drops s0, each update step after the first
  // appends the new state at the top; after the last step the line is back in order.
  always_ff @(posedge clk) begin
    if (!rst_n || (cmd.load && in_data.restart)) begin
      for (int j = 0; j < ORDER; j++) begin
        state_r[j] <= '0;
      end
    end else if (cmd.round || cmd.acc) begin
      for (int j = 0; j < ORDER - 1; j++) begin
        state_r[j] <= state_r[j+1];
      end
      state_r[ORDER-1] <= cmd.acc ? s_sat : '0;
    end
  end

  assign out_data = out_data_r;

  a_round_uses_clear_state: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load && in_data.restart |=> state_r[0] == '0)
    else $error("restart did not clear the delay state");

  a_clip_matches_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.round && !y_clip |=> y_r == $past(y_full[SAMPLE_W-1:0]))
    else $error("unclipped output differs from the rounded sum");

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.round, cmd.mul || cmd.acc, cmd.publish}))
    else $error("datapath commands overlap");

endmodule

`default_nettype wire

@@ design/iir_filter_transposed_df2_top.sv @@
// ----------------------------------------------------------------------------
// IIR transposed direct form II filter, top level
// Order 1 to 3 filter with Q3.14 coefficients and 40-bit saturating states.
// ----------------------------------------------------------------------------
// Flow: an item is taken only while idle; in_stall holds off the next item
// through the round, update and publish steps, paced by the pair of shared
// 18x16 multipliers stepping once per delay state.
// Reset: rst_n is synchronous; delay states clear, b0 resets to 1.0 and all
// other coefficients to zero. The configuration port is always ready.
`default_nettype none

module iir_filter_transposed_df2_top #(
  parameter int FILTER_ORDER = iir_tdf2_pkg::FILTER_ORDER_DEF
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  iir_tdf2_pkg::iir_in_t                 in_data,
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output iir_tdf2_pkg::iir_out_t                out_data,
  input  wire                                   cfg_valid,
  output logic                                  cfg_ready,
  input  wire [iir_tdf2_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [iir_tdf2_pkg::COEF_W-1:0]        cfg_data
);
  import iir_tdf2_pkg::*;

  localparam int ORDER  = (FILTER_ORDER < 1) ? 1 :
                          ((FILTER_ORDER > ORDER_MAX) ? ORDER_MAX : FILTER_ORDER);
  localparam int STEP_W = $clog2(ORDER + 1);

  iir_cmd_t          cmd;
  logic [STEP_W-1:0] step_idx;

  assign cfg_ready = 1'b1;

  iir_tdf2_ctrl #(
    .ORDER  (ORDER),
    .STEP_W (STEP_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .step_idx  (step_idx)
  );

  iir_tdf2_dp #(
    .ORDER  (ORDER),
    .STEP_W (STEP_W)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .step_idx  (step_idx)
  );

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// IIR transposed direct form II filter testbench
// Drives samples and coefficient sets into the filter, predicts each output
// with a bit-exact fixed-point model and checks every result in order.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import iir_tdf2_pkg::*;

  localparam int ORDER = (FILTER_ORDER_DEF < 1) ? 1 :
                         ((FILTER_ORDER_DEF > ORDER_MAX) ? ORDER_MAX : FILTER_ORDER_DEF);
  localparam int LATENCY    = ORDER + 3;
  localparam int DRAIN      = 2 * (ORDER + 4);
  localparam int CYCLE_CAP  = 400000;
  localparam int PHASE_ITEMS = 250;

  localparam longint STATE_HI = (64'sd1 <<< 39) - 1;
  localparam longint STATE_LO = -(64'sd1 <<< 39);

  // Index 7 decodes to no register; writes to it must be dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;

  localparam logic [COEF_W-1:0] COEF_MAX = 18'h1ffff;
  localparam logic [COEF_W-1:0] COEF_MIN = 18'h20000;
  localparam logic [COEF_W-1:0] COEF_ZERO = 18'h00000;

  class iir_scoreboard;
    int       order;
    longint   coef_b [4];
    longint   coef_a [4];
    longint   delay_line [3];
    iir_out_t expected_q [$];
    int       errors;

    function new(int order_in);
      order = order_in;
      coef_b = '{longint'(COEF_B0_RESET), 0, 0, 0};
      coef_a = '{0, 0, 0, 0};
      delay_line = '{0, 0, 0};
      errors = 0;
    endfunction

    function void set_coef(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] val);
      longint v;
      v = longint'($signed(val));
      case (idx)
        CFG_COEF_B0: coef_b[0] = v;
        CFG_COEF_B1: coef_b[1] = v;
        CFG_COEF_B2: coef_b[2] = v;
        CFG_COEF_B3: coef_b[3] = v;
        CFG_COEF_A1: coef_a[1] = v;
        CFG_COEF_A2: coef_a[2] = v;
        CFG_COEF_A3: coef_a[3] = v;
        default: ;
      endcase
    endfunction

    function void note_input(iir_in_t item);
      longint   x;
      longint   acc;
      longint   y;
      longint   s;
      bit       clip;
      iir_out_t res;
      x = longint'($signed(item.sample));
      clip = 1'b0;
      if (item.restart)
        delay_line = '{0, 0, 0};
      acc = coef_b[0] * x + delay_line[0];
      // Arithmetic shift floors, so adding half an LSB rounds half up.
      y = (acc + 8192) >>> FRAC_W;
      if (y > 32767) begin
        y = 32767;
        clip = 1'b1;
      end else if (y < -32768) begin
        y = -32768;
        clip = 1'b1;
      end
      // Ascending order so each state still sees the old value above it.
      for (int k = 0; k < order; k++) begin
        s = coef_b[k+1] * x - coef_a[k+1] * y;
        if (k + 1 < order)
          s += delay_line[k+1];
        if (s > STATE_HI)
          s = STATE_HI;
        else if (s < STATE_LO)
          s = STATE_LO;
        delay_line[k] = s;
      end
      res.filtered = 16'(y);
      res.clipped = clip;
      expected_q.push_back(res);
    endfunction

    task note_mismatch(string msg);
      $display("%0t mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_result(iir_out_t got);
      iir_out_t want;
      if (expected_q.size() == 0) begin
        note_mismatch($sformatf("result %0d with no item pending", $signed(got.filtered)));
      end else begin
        want = expected_q.pop_front();
        if (got.filtered !== want.filtered)
          note_mismatch($sformatf("filtered %0d, expected %0d",
                                  $signed(got.filtered), $signed(want.filtered)));
        if (got.clipped !== want.clipped)
          note_mismatch($sformatf("clipped %0b, expected %0b", got.clipped, want.clipped));
      end
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  iir_in_t              in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  iir_out_t             out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COEF_W-1:0]    cfg_data = '0;

  iir_scoreboard sb;
  bit            calm = 1'b0;
  int            cycles = 0;

  iir_filter_transposed_df2_top #(.FILTER_ORDER(FILTER_ORDER_DEF)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic bit take_break();
    return !calm && ($urandom_range(99) < 30);
  endfunction

  always @(posedge clk) begin
    out_stall <= take_break();
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_data);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_CAP) begin
      $display("tb: errors");
      $finish;
    end
  end

  task automatic send_item(iir_in_t item);
    while (take_break()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
    sb.note_input(item);
  endtask

  task automatic send_sample(int x, bit restart);
    iir_in_t item;
    item.sample = 16'(x);
    item.restart = restart;
    send_item(item);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_coef(idx, val);
  endtask

  // Waits until every expected result is back and the datapath has gone quiet.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic load_coefs(logic [COEF_W-1:0] b0, logic [COEF_W-1:0] b1,
                            logic [COEF_W-1:0] b2, logic [COEF_W-1:0] b3,
                            logic [COEF_W-1:0] a1, logic [COEF_W-1:0] a2,
                            logic [COEF_W-1:0] a3);
    settle();
    write_reg(CFG_COEF_B0, b0);
    write_reg(CFG_COEF_B1, b1);
    write_reg(CFG_COEF_B2, b2);
    write_reg(CFG_IDX_UNUSED, 18'($urandom));
    write_reg(CFG_COEF_B3, b3);
    write_reg(CFG_COEF_A1, a1);
    write_reg(CFG_COEF_A2, a2);
    write_reg(CFG_COEF_A3, a3);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [COEF_W-1:0] rand_coef(int span);
    int v;
    v = int'($urandom_range(0, 2 * span - 1)) - span;
    return v[COEF_W-1:0];
  endfunction

  function automatic iir_in_t make_item(int restart_pct);
    iir_in_t item;
    int      pick;
    pick = $urandom_range(9);
    if (pick == 0) begin
      case ($urandom_range(3))
        0: item.sample = 16'h7fff;
        1: item.sample = 16'h8000;
        2: item.sample = 16'h0000;
        default: item.sample = 16'hffff;
      endcase
    end else if (pick < 4) begin
      item.sample = 16'(int'($urandom_range(0, 511)) - 256);
    end else begin
      item.sample = 16'($urandom);
    end
    item.restart = ($urandom_range(99) < restart_pct);
    return item;
  endfunction

  initial begin
    int restart_pct;
    sb = new(ORDER);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset coefficients: unity gain, so the output follows the input.
    send_sample(0, 1'b0);
    send_sample(32767, 1'b0);
    send_sample(-32768, 1'b0);
    send_sample(1, 1'b0);
    send_sample(-1, 1'b0);
    send_sample(12345, 1'b1);

    // A gain of one half puts odd samples exactly on the rounding boundary.
    load_coefs(18'd8192, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO);
    send_sample(1, 1'b0);
    send_sample(-1, 1'b0);
    send_sample(3, 1'b0);
    send_sample(-3, 1'b0);

    // Largest gains with regenerative feedback drive the output into both rails.
    load_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MIN, COEF_MIN, COEF_MIN);
    send_sample(32767, 1'b1);
    send_sample(32767, 1'b0);
    send_sample(-32768, 1'b0);
    send_sample(-32768, 1'b1);
    send_sample(0, 1'b0);

    load_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
    send_sample(-32768, 1'b1);
    send_sample(32767, 1'b0);
    send_sample(0, 1'b0);
    send_sample(100, 1'b0);

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          // Stable low-pass with a triple pole near one half.
          load_coefs(18'd1024, 18'd3072, 18'd3072, 18'd1024,
                     rand_coef(1) - 18'd24576, 18'd12288, rand_coef(1) - 18'd2048);
          restart_pct = 1;
        end
        1, 3: begin
          load_coefs(rand_coef(4096), rand_coef(4096), rand_coef(4096), rand_coef(4096),
                     rand_coef(4096), rand_coef(4096), rand_coef(4096));
          restart_pct = 2;
        end
        4: begin
          load_coefs(COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX);
          restart_pct = 10;
        end
        default: begin
          load_coefs(rand_coef(131072), rand_coef(131072), rand_coef(131072),
                     rand_coef(131072), rand_coef(131072), rand_coef(131072),
                     rand_coef(131072));
          restart_pct = 8;
        end
      endcase
      calm = (phase == 3);
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_item(make_item(restart_pct));
      calm = 1'b0;
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (sb.errors == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule
